// ===== rtl/core/assert_macros.svh =====
// Assertion macros used by the checker file of this block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on clk and disabled in reset.
`define EYX_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on clk and disabled in reset.
`define EYX_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/core/eyx_pkg.sv =====
// Package with payload types and fixed widths of the ellipse y extent block.
package eyx_pkg;

    localparam int COEF_W = 24;
    localparam int PROD_W = 48;
    localparam int CTR_W  = PROD_W + 1;
    localparam int DEN_W  = 50;
    localparam int MP_W   = 52;
    localparam int E_W    = 76;
    localparam int D_W    = 98;
    localparam int ROOT_W = D_W / 2;
    localparam int NUM_W  = 52;
    localparam int Q_W    = 32;
    localparam int FRAC_W = 16;

    typedef struct packed {
        logic signed [COEF_W-1:0] coef_xx;
        logic signed [COEF_W-1:0] coef_xy;
        logic signed [COEF_W-1:0] coef_yy;
        logic signed [COEF_W-1:0] coef_x;
        logic signed [COEF_W-1:0] coef_y;
        logic signed [COEF_W-1:0] coef_const;
    } eyx_in_t;

    typedef struct packed {
        logic signed [Q_W-1:0] y_min;
        logic signed [Q_W-1:0] y_max;
        logic                  error;
    } eyx_out_t;

    typedef struct packed {
        logic                    err;
        logic signed [DEN_W-1:0] den;
        logic signed [CTR_W-1:0] center;
    } eyx_side_t;

endpackage

// ===== rtl/core/eyx_disc.sv =====
// Six-stage front end forming the denominator, center numerator and discriminant.
module eyx_disc (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          adv,
    input  logic                          in_valid,
    input  eyx_pkg::eyx_in_t              coef,
    output logic                          out_valid,
    output eyx_pkg::eyx_side_t            side,
    output logic [eyx_pkg::D_W-1:0]       rad
);
    import eyx_pkg::*;

    logic                     s1_valid_reg;
    logic signed [COEF_W-1:0] s1_a0_reg, s1_a3_reg, s1_a4_reg, s1_a5_reg;
    logic signed [PROD_W-1:0] s1_p02_reg, s1_p11_reg, s1_p04_reg, s1_p13_reg, s1_p23_reg;
    logic signed [PROD_W-1:0] s1_p02_next, s1_p11_next, s1_p04_next, s1_p13_next, s1_p23_next;

    logic                     s2_valid_reg;
    logic signed [COEF_W-1:0] s2_a0_reg, s2_a3_reg, s2_a4_reg, s2_a5_reg;
    logic signed [PROD_W-1:0] s2_p23_reg;
    logic signed [DEN_W-1:0]  s2_den_reg, s2_den_next;
    logic signed [CTR_W-1:0]  s2_diff_reg, s2_diff_next, s2_ctr_reg, s2_ctr_next;

    logic                     s3_valid_reg, s3_bad_reg;
    logic signed [COEF_W-1:0] s3_a0_reg;
    logic signed [DEN_W-1:0]  s3_den_reg;
    logic signed [CTR_W-1:0]  s3_ctr_reg;
    logic signed [MP_W-1:0]   s3_m1l_reg, s3_m1h_reg, s3_m2l_reg, s3_m2h_reg, s3_m3l_reg, s3_m3h_reg;
    logic signed [MP_W-1:0]   s3_m1l_next, s3_m1h_next, s3_m2l_next, s3_m2h_next;
    logic signed [MP_W-1:0]   s3_m3l_next, s3_m3h_next;

    logic                     s4_valid_reg, s4_bad_reg;
    logic signed [COEF_W-1:0] s4_a0_reg;
    logic signed [DEN_W-1:0]  s4_den_reg;
    logic signed [CTR_W-1:0]  s4_ctr_reg;
    logic signed [E_W-1:0]    s4_e_reg, s4_e_next;

    logic                     s5_valid_reg, s5_bad_reg;
    logic signed [DEN_W-1:0]  s5_den_reg;
    logic signed [CTR_W-1:0]  s5_ctr_reg;
    logic signed [MP_W-1:0]   s5_pl_reg, s5_pm_reg, s5_ph_reg, s5_pl_next, s5_pm_next, s5_ph_next;

    logic                     s6_valid_reg;
    eyx_side_t                s6_side_reg;
    logic signed [D_W-1:0]    s6_d_reg, s6_d_next;

    always_comb
    begin
        s1_p02_next = $signed(coef.coef_xx) * $signed(coef.coef_yy);
        s1_p11_next = $signed(coef.coef_xy) * $signed(coef.coef_xy);
        s1_p04_next = $signed(coef.coef_xx) * $signed(coef.coef_y);
        s1_p13_next = $signed(coef.coef_xy) * $signed(coef.coef_x);
        s1_p23_next = $signed(coef.coef_yy) * $signed(coef.coef_x);

        s2_den_next  = (DEN_W'(s1_p02_reg) <<< 2) - DEN_W'(s1_p11_reg);
        s2_diff_next = CTR_W'(s1_p04_reg) - CTR_W'(s1_p13_reg);
        s2_ctr_next  = CTR_W'(s1_p13_reg) - (CTR_W'(s1_p04_reg) <<< 1);

        s3_m1l_next = $signed({1'b0, s2_den_reg[23:0]}) * s2_a5_reg;
        s3_m1h_next = $signed(s2_den_reg[DEN_W-1:24]) * s2_a5_reg;
        s3_m2l_next = $signed({1'b0, s2_diff_reg[23:0]}) * s2_a4_reg;
        s3_m2h_next = $signed(s2_diff_reg[CTR_W-1:24]) * s2_a4_reg;
        s3_m3l_next = $signed({1'b0, s2_p23_reg[23:0]}) * s2_a3_reg;
        s3_m3h_next = $signed(s2_p23_reg[PROD_W-1:24]) * s2_a3_reg;

        s4_e_next = (E_W'(s3_m2h_reg) <<< 24) + E_W'(s3_m2l_reg)
                  + (E_W'(s3_m3h_reg) <<< 24) + E_W'(s3_m3l_reg)
                  - (E_W'(s3_m1h_reg) <<< 24) - E_W'(s3_m1l_reg);

        s5_pl_next = $signed({1'b0, s4_e_reg[23:0]}) * s4_a0_reg;
        s5_pm_next = $signed({1'b0, s4_e_reg[47:24]}) * s4_a0_reg;
        s5_ph_next = $signed(s4_e_reg[E_W-1:48]) * s4_a0_reg;

        s6_d_next = (D_W'(s5_ph_reg) <<< 48) + (D_W'(s5_pm_reg) <<< 24) + D_W'(s5_pl_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
            s4_valid_reg <= 1'b0;
            s5_valid_reg <= 1'b0;
            s6_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            s1_valid_reg <= in_valid;
            s2_valid_reg <= s1_valid_reg;
            s3_valid_reg <= s2_valid_reg;
            s4_valid_reg <= s3_valid_reg;
            s5_valid_reg <= s4_valid_reg;
            s6_valid_reg <= s5_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s1_a0_reg  <= coef.coef_xx;
            s1_a3_reg  <= coef.coef_x;
            s1_a4_reg  <= coef.coef_y;
            s1_a5_reg  <= coef.coef_const;
            s1_p02_reg <= s1_p02_next;
            s1_p11_reg <= s1_p11_next;
            s1_p04_reg <= s1_p04_next;
            s1_p13_reg <= s1_p13_next;
            s1_p23_reg <= s1_p23_next;

            s2_a0_reg   <= s1_a0_reg;
            s2_a3_reg   <= s1_a3_reg;
            s2_a4_reg   <= s1_a4_reg;
            s2_a5_reg   <= s1_a5_reg;
            s2_p23_reg  <= s1_p23_reg;
            s2_den_reg  <= s2_den_next;
            s2_diff_reg <= s2_diff_next;
            s2_ctr_reg  <= s2_ctr_next;

            s3_bad_reg <= !(s2_den_reg > 0);
            s3_a0_reg  <= s2_a0_reg;
            s3_den_reg <= s2_den_reg;
            s3_ctr_reg <= s2_ctr_reg;
            s3_m1l_reg <= s3_m1l_next;
            s3_m1h_reg <= s3_m1h_next;
            s3_m2l_reg <= s3_m2l_next;
            s3_m2h_reg <= s3_m2h_next;
            s3_m3l_reg <= s3_m3l_next;
            s3_m3h_reg <= s3_m3h_next;

            s4_bad_reg <= s3_bad_reg;
            s4_a0_reg  <= s3_a0_reg;
            s4_den_reg <= s3_den_reg;
            s4_ctr_reg <= s3_ctr_reg;
            s4_e_reg   <= s4_e_next;

            s5_bad_reg <= s4_bad_reg;
            s5_den_reg <= s4_den_reg;
            s5_ctr_reg <= s4_ctr_reg;
            s5_pl_reg  <= s5_pl_next;
            s5_pm_reg  <= s5_pm_next;
            s5_ph_reg  <= s5_ph_next;

            s6_side_reg.err    <= s5_bad_reg || s6_d_next[D_W-1];
            s6_side_reg.den    <= s5_den_reg;
            s6_side_reg.center <= s5_ctr_reg;
            s6_d_reg           <= s6_d_next;
        end
    end

    assign out_valid = s6_valid_reg;
    assign side      = s6_side_reg;
    assign rad       = s6_d_reg;

endmodule

// ===== rtl/core/eyx_sqrt.sv =====
// Pipelined floor square root, one result bit per stage.
module eyx_sqrt (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          adv,
    input  logic                          in_valid,
    input  eyx_pkg::eyx_side_t            side_in,
    input  logic [eyx_pkg::D_W-1:0]       rad,
    output logic                          out_valid,
    output eyx_pkg::eyx_side_t            side_out,
    output logic [eyx_pkg::ROOT_W-1:0]    root
);
    import eyx_pkg::*;

    localparam int REM_W = ROOT_W + 3;

    logic              valid_reg [1:ROOT_W];
    eyx_side_t         side_reg  [1:ROOT_W];
    logic [REM_W-1:0]  rem_reg   [1:ROOT_W];
    logic [ROOT_W-1:0] root_reg  [1:ROOT_W];
    logic [D_W-1:0]    rad_reg   [1:ROOT_W];

    for (genvar k = 0; k < ROOT_W; k++)
    begin : g_stage
        logic              v_in;
        eyx_side_t         s_in;
        logic [REM_W-1:0]  rem_in, rem_sh, trial, rem_next;
        logic [ROOT_W-1:0] root_in, root_next;
        logic [D_W-1:0]    rad_in, rad_next;
        logic              ge;

        if (k == 0)
        begin : g_first
            assign v_in    = in_valid;
            assign s_in    = side_in;
            assign rem_in  = '0;
            assign root_in = '0;
            assign rad_in  = rad;
        end
        else
        begin : g_rest
            assign v_in    = valid_reg[k];
            assign s_in    = side_reg[k];
            assign rem_in  = rem_reg[k];
            assign root_in = root_reg[k];
            assign rad_in  = rad_reg[k];
        end

        always_comb
        begin
            rem_sh    = {rem_in[REM_W-3:0], rad_in[D_W-1 -: 2]};
            trial     = REM_W'({root_in, 2'b01});
            ge        = (rem_sh >= trial);
            rem_next  = ge ? (rem_sh - trial) : rem_sh;
            root_next = {root_in[ROOT_W-2:0], ge};
            rad_next  = {rad_in[D_W-3:0], 2'b00};
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                valid_reg[k+1] <= 1'b0;
            end
            else if (adv)
            begin
                valid_reg[k+1] <= v_in;
            end
        end

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                side_reg[k+1] <= s_in;
                rem_reg[k+1]  <= rem_next;
                root_reg[k+1] <= root_next;
                rad_reg[k+1]  <= rad_next;
            end
        end
    end

    assign out_valid = valid_reg[ROOT_W];
    assign side_out  = side_reg[ROOT_W];
    assign root      = root_reg[ROOT_W];

endmodule

// ===== rtl/core/eyx_div.sv =====
// One pipelined Q16.16 divider lane with truncation, saturation and error zeroing.
module eyx_div (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              adv,
    input  logic                              in_valid,
    input  logic                              err_in,
    input  logic signed [eyx_pkg::DEN_W-1:0]  den,
    input  logic signed [eyx_pkg::NUM_W-1:0]  num,
    output logic                              out_valid,
    output logic                              err,
    output logic signed [eyx_pkg::Q_W-1:0]    q
);
    import eyx_pkg::*;

    localparam logic [Q_W:0] MAG_OVF = (Q_W+1)'(1) << Q_W;
    localparam logic [Q_W:0] NEG_LIM = (Q_W+1)'(1) << (Q_W - 1);
    localparam logic [Q_W:0] POS_LIM = NEG_LIM - (Q_W+1)'(1);

    logic             valid_reg [0:Q_W];
    logic             err_reg   [0:Q_W];
    logic             neg_reg   [0:Q_W];
    logic             ovf_reg   [0:Q_W];
    logic [DEN_W-1:0] den_reg   [0:Q_W];
    logic [DEN_W-1:0] rem_reg   [0:Q_W];
    logic [Q_W-1:0]   low_reg   [0:Q_W];
    logic [Q_W-1:0]   quo_reg   [0:Q_W];

    logic [NUM_W-1:0] mag_next;
    logic             ovf_next;

    logic                  out_valid_reg, out_err_reg;
    logic signed [Q_W-1:0] out_q_reg, out_q_next;
    logic [Q_W:0]          fin_mag, fin_lim, fin_res;

    always_comb
    begin
        mag_next = num[NUM_W-1] ? NUM_W'(-num) : NUM_W'(num);
        ovf_next = (DEN_W'(mag_next[NUM_W-1:FRAC_W]) >= den[DEN_W-1:0]);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg[0] <= 1'b0;
        end
        else if (adv)
        begin
            valid_reg[0] <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            err_reg[0] <= err_in;
            neg_reg[0] <= num[NUM_W-1];
            ovf_reg[0] <= ovf_next;
            den_reg[0] <= den[DEN_W-1:0];
            rem_reg[0] <= DEN_W'(mag_next[NUM_W-1:FRAC_W]);
            low_reg[0] <= {mag_next[FRAC_W-1:0], {(Q_W-FRAC_W){1'b0}}};
            quo_reg[0] <= '0;
        end
    end

    for (genvar k = 0; k < Q_W; k++)
    begin : g_step
        logic [DEN_W:0]   rem_sh;
        logic             ge;
        logic [DEN_W-1:0] rem_next;

        always_comb
        begin
            rem_sh   = {rem_reg[k], low_reg[k][Q_W-1]};
            ge       = (rem_sh >= {1'b0, den_reg[k]});
            rem_next = ge ? DEN_W'(rem_sh - {1'b0, den_reg[k]}) : DEN_W'(rem_sh);
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                valid_reg[k+1] <= 1'b0;
            end
            else if (adv)
            begin
                valid_reg[k+1] <= valid_reg[k];
            end
        end

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                err_reg[k+1] <= err_reg[k];
                neg_reg[k+1] <= neg_reg[k];
                ovf_reg[k+1] <= ovf_reg[k];
                den_reg[k+1] <= den_reg[k];
                rem_reg[k+1] <= rem_next;
                low_reg[k+1] <= {low_reg[k][Q_W-2:0], 1'b0};
                quo_reg[k+1] <= {quo_reg[k][Q_W-2:0], ge};
            end
        end
    end

    always_comb
    begin
        fin_mag = ovf_reg[Q_W] ? MAG_OVF : {1'b0, quo_reg[Q_W]};
        if (neg_reg[Q_W])
        begin
            fin_lim = (fin_mag > NEG_LIM) ? NEG_LIM : fin_mag;
            fin_res = -fin_lim;
        end
        else
        begin
            fin_lim = (fin_mag > POS_LIM) ? POS_LIM : fin_mag;
            fin_res = fin_lim;
        end
        out_q_next = err_reg[Q_W] ? '0 : $signed(fin_res[Q_W-1:0]);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            out_valid_reg <= valid_reg[Q_W];
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            out_err_reg <= err_reg[Q_W];
            out_q_reg   <= out_q_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign err       = out_err_reg;
    assign q         = out_q_reg;

endmodule

// ===== rtl/core/ellipse_y_extent.sv =====
// Top level of the pipelined ellipse y extent block.
//  channel | handshake              | payload
//  coef    | coef_valid, coef_ready | eyx_in_t, six Q12.12 conic coefficients
//  ext     | ext_valid, ext_ready   | eyx_out_t, y_min and y_max in Q16.16, error
// One item enters per cycle unless the pipeline stalls; results leave in the order that items entered.
// Most of the pipeline depth lies in the 49 square root stages and the 32 divider stages.
// Reset clears only the valid bits of every stage.
// When ext holds a result that is not taken, the whole pipeline stalls and
// coef_ready drops; nothing is lost or repeated.
module ellipse_y_extent (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              coef_valid,
    output logic              coef_ready,
    input  eyx_pkg::eyx_in_t  coef,
    output logic              ext_valid,
    input  logic              ext_ready,
    output eyx_pkg::eyx_out_t ext
);
    import eyx_pkg::*;

    logic              adv;
    logic              dc_valid, sq_valid;
    eyx_side_t         dc_side, sq_side;
    logic [D_W-1:0]    dc_rad;
    logic [ROOT_W-1:0] sq_root;

    logic                    nm_valid_reg, nm_err_reg;
    logic signed [DEN_W-1:0] nm_den_reg;
    logic signed [NUM_W-1:0] nm_lo_reg, nm_hi_reg, nm_lo_next, nm_hi_next, two_root;

    logic                  min_valid, max_valid, min_err, max_err;
    logic signed [Q_W-1:0] min_q, max_q;

    assign adv        = !ext_valid || ext_ready;
    assign coef_ready = adv;

    eyx_disc u_disc (
        .clk       (clk),
        .rst_n     (rst_n),
        .adv       (adv),
        .in_valid  (coef_valid),
        .coef      (coef),
        .out_valid (dc_valid),
        .side      (dc_side),
        .rad       (dc_rad)
    );

    eyx_sqrt u_sqrt (
        .clk       (clk),
        .rst_n     (rst_n),
        .adv       (adv),
        .in_valid  (dc_valid),
        .side_in   (dc_side),
        .rad       (dc_rad),
        .out_valid (sq_valid),
        .side_out  (sq_side),
        .root      (sq_root)
    );

    always_comb
    begin
        two_root   = NUM_W'($signed({1'b0, sq_root})) <<< 1;
        nm_lo_next = NUM_W'(sq_side.center) - two_root;
        nm_hi_next = NUM_W'(sq_side.center) + two_root;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            nm_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            nm_valid_reg <= sq_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            nm_err_reg <= sq_side.err;
            nm_den_reg <= sq_side.den;
            nm_lo_reg  <= nm_lo_next;
            nm_hi_reg  <= nm_hi_next;
        end
    end

    eyx_div u_div_min (
        .clk       (clk),
        .rst_n     (rst_n),
        .adv       (adv),
        .in_valid  (nm_valid_reg),
        .err_in    (nm_err_reg),
        .den       (nm_den_reg),
        .num       (nm_lo_reg),
        .out_valid (min_valid),
        .err       (min_err),
        .q         (min_q)
    );

    eyx_div u_div_max (
        .clk       (clk),
        .rst_n     (rst_n),
        .adv       (adv),
        .in_valid  (nm_valid_reg),
        .err_in    (nm_err_reg),
        .den       (nm_den_reg),
        .num       (nm_hi_reg),
        .out_valid (max_valid),
        .err       (max_err),
        .q         (max_q)
    );

    assign ext_valid = min_valid && max_valid;
    assign ext.y_min = min_q;
    assign ext.y_max = max_q;
    assign ext.error = min_err || max_err;

endmodule

// ===== rtl/core/eyx_checker.sv =====
// Port-level checker for the ellipse y extent block and its bind.
`include "assert_macros.svh"

module eyx_checker (
    input logic              clk,
    input logic              rst_n,
    input logic              coef_valid,
    input logic              coef_ready,
    input eyx_pkg::eyx_in_t  coef,
    input logic              ext_valid,
    input logic              ext_ready,
    input eyx_pkg::eyx_out_t ext
);
    import eyx_pkg::*;

    `EYX_ASSERT_IMP(a_err_zero, ext_valid && ext.error, ext.y_min == '0 && ext.y_max == '0, "error result with nonzero limits")
    `EYX_ASSERT_IMP(a_order, ext_valid && !ext.error, $signed(ext.y_min) <= $signed(ext.y_max), "y_min above y_max")
    `EYX_ASSERT_IMP(a_ready, !ext_valid, coef_ready, "input stalled with empty output")
    `EYX_ASSERT_NXT(a_hold, ext_valid && !ext_ready, ext_valid && $stable(ext), "stalled result changed")

endmodule

bind ellipse_y_extent eyx_checker u_eyx_checker (.*);
